// File: hdl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// Used by uer_seq, uer_scale and ultrasonic_echo_ranger; depends on nothing.
package uer_pkg;

   // widths of the configuration and result fields
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;
   localparam int CountWidth    = 16;
   localparam int RangeWidth    = 10;

   localparam logic [RangeWidth-1:0] RANGE_MAX = 10'd1023;

   // register indexes on the configuration port
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_TRIGGER_TICKS     = 3'd0,
      CSR_WAIT_LIMIT        = 3'd1,
      CSR_WAIT_FAULT_LEVEL  = 3'd2,
      CSR_WIDTH_LIMIT       = 3'd3,
      CSR_WIDTH_FAULT_LEVEL = 3'd4,
      CSR_SCALE_RECIP       = 3'd5,
      CSR_NEAR_LOW          = 3'd6,
      CSR_NEAR_HIGH         = 3'd7
   } csr_index_type;

   // register values after reset
   localparam logic [7:0]            TRIGGER_TICKS_RST     = 8'd10;
   localparam logic [CountWidth-1:0] WAIT_LIMIT_RST        = 16'd1000;
   localparam logic [CountWidth-1:0] WAIT_FAULT_LEVEL_RST  = 16'd900;
   localparam logic [CountWidth-1:0] WIDTH_LIMIT_RST       = 16'd25000;
   localparam logic [CountWidth-1:0] WIDTH_FAULT_LEVEL_RST = 16'd24990;
   localparam logic [CountWidth-1:0] SCALE_RECIP_RST       = 16'd1114;
   localparam logic [RangeWidth-1:0] NEAR_LOW_RST          = 10'd1;
   localparam logic [RangeWidth-1:0] NEAR_HIGH_RST         = 10'd6;

   // measurement phase
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_TRIG  = 2'd1,
      PH_WAIT  = 2'd2,
      PH_WIDTH = 2'd3
   } phase_type;

   // measurement status codes
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_ECHO = 2'd1,
      STATUS_OVERRUN = 2'd2
   } status_type;

   // all configuration registers
   typedef struct packed {
      logic [7:0]            trigger_ticks;
      logic [CountWidth-1:0] wait_limit;
      logic [CountWidth-1:0] wait_fault_level;
      logic [CountWidth-1:0] width_limit;
      logic [CountWidth-1:0] width_fault_level;
      logic [CountWidth-1:0] scale_recip;
      logic [RangeWidth-1:0] near_low;
      logic [RangeWidth-1:0] near_high;
   } cfg_type;

   // per-tick outcome from the sequencer to the scaler and result register
   typedef struct packed {
      logic                  trigger;
      logic                  busy;
      logic                  done;
      status_type            status;
      logic [CountWidth-1:0] width;
   } tick_type;

endpackage

// File: hdl/uer_seq.sv
// Measurement sequencer: phase register, tick counter and per-tick decisions.
// Depends on uer_pkg.
module uer_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic             start_req,
   input  logic             echo_level,
   input  uer_pkg::cfg_type cfg,
   output uer_pkg::tick_type tick
);
   import uer_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [CountWidth-1:0] count_inc;
   logic                  width_over;

   assign count_inc = count_ff + 16'd1;

   // state registers advance once per processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // next phase, counter and tick outcome
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      tick         = '0;
      tick.status  = STATUS_OK;
      width_over   = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start_req) begin
               tick.trigger = 1'b1;
               if (cfg.trigger_ticks <= 8'd1) begin
                  phase_in = PH_WAIT;
                  count_in = '0;
               end else begin
                  phase_in = PH_TRIG;
                  count_in = 16'd1;
               end
            end
         end
         PH_TRIG: begin
            tick.trigger = 1'b1;
            if (count_inc >= {8'd0, cfg.trigger_ticks}) begin
               phase_in = PH_WAIT;
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end
         PH_WAIT: begin
            if (echo_level) begin
               if (count_ff > cfg.wait_fault_level) begin
                  tick.done   = 1'b1;
                  tick.status = STATUS_NO_ECHO;
                  phase_in    = PH_IDLE;
                  count_in    = '0;
               end else begin
                  phase_in = PH_WIDTH;
                  count_in = '0;
               end
            end else if (count_inc >= cfg.wait_limit) begin
               tick.done   = 1'b1;
               tick.status = STATUS_NO_ECHO;
               phase_in    = PH_IDLE;
               count_in    = '0;
            end else begin
               count_in = count_inc;
            end
         end
         PH_WIDTH: begin
            if (echo_level && (count_inc < cfg.width_limit)) begin
               count_in = count_inc;
            end else begin
               // echo fell or width limit reached
               tick.done  = 1'b1;
               tick.width = echo_level ? count_inc : count_ff;
               width_over = tick.width > cfg.width_fault_level;
               tick.status = width_over ? STATUS_OVERRUN : STATUS_OK;
               phase_in   = PH_IDLE;
               count_in   = '0;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            count_in = '0;
         end
      endcase
      tick.busy = (phase_in != PH_IDLE);
   end

endmodule

// File: hdl/uer_scale.sv
// Width-to-distance scaling with saturation and the near-window compare.
// Depends on uer_pkg.
module uer_scale (
   input  uer_pkg::tick_type                  tick,
   input  uer_pkg::cfg_type                   cfg,
   output logic [uer_pkg::RangeWidth-1:0]     range_value,
   output logic                               obstacle_near
);
   import uer_pkg::*;

   logic [2*CountWidth-1:0] product;
   logic [CountWidth-1:0]   dist_full;
   logic [RangeWidth-1:0]   dist_sat;
   logic                    good;

   // Q16 reciprocal multiply, keep the integer part
   assign product   = tick.width * cfg.scale_recip;
   assign dist_full = product[2*CountWidth-1:CountWidth];
   assign dist_sat  = (dist_full > {6'd0, RANGE_MAX}) ? RANGE_MAX
                                                       : dist_full[RangeWidth-1:0];

   // only a finished good measurement reports a distance
   assign good          = tick.done && (tick.status == STATUS_OK);
   assign range_value   = good ? dist_sat : '0;
   assign obstacle_near = good && (dist_sat >= cfg.near_low) && (dist_sat <= cfg.near_high);

endmodule

// File: hdl/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: channel registers and config registers.
// Depends on uer_pkg, uer_seq and uer_scale.
//
// Usage
//   Each transaction on the req_ channel is one timer tick: a start request and
//   the sampled echo pin level. Every request yields exactly one rsp_ transaction
//   carrying the trigger drive level, busy, done, status, range and near flag.
//   A measurement drives the trigger, waits for the echo rise and counts the
//   echo width; done marks the tick it ends, with status ok, no echo or overrun.
//   A request accepted at one edge is in the input register; its result is
//   loaded into the result register, raising rsp_valid, once that register is
//   empty or rsp_stall is low. Throughput is one tick per cycle while rsp_stall
//   is low. The phase and tick counter load at the same edge as the result.
//   Configuration is written through csr_ at any edge with csr_write_en high.
//   Reset clears the phase, counter and both channel valid flags and restores
//   the register defaults. When rsp_stall is high the result holds, one more
//   request may sit in the input register, and then req_stall rises.
module ultrasonic_echo_ranger (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_start_req,
   input  logic                                 req_echo_level,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_trigger_out,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_done_res,
   output logic [1:0]                           rsp_status,
   output logic [uer_pkg::RangeWidth-1:0]       rsp_range_value,
   output logic                                 rsp_obstacle_near,
   // configuration write port
   input  logic                                 csr_write_en,
   input  logic [uer_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [uer_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import uer_pkg::*;

   cfg_type               cfg_ff;
   logic                  in_vld_ff, in_vld_in;
   logic                  in_start_ff, in_echo_ff;
   logic                  out_vld_ff, out_vld_in;
   tick_type              tick;
   logic [RangeWidth-1:0] range_value;
   logic                  obstacle_near;
   logic                  req_take;
   logic                  advance;
   csr_index_type         csr_sel;

   // handshake control
   assign advance    = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall  = in_vld_ff && !advance;
   assign req_take   = req_valid && !req_stall;
   assign in_vld_in  = req_take || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && rsp_stall);
   assign csr_sel    = csr_index_type'(csr_index);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_ticks     <= TRIGGER_TICKS_RST;
         cfg_ff.wait_limit        <= WAIT_LIMIT_RST;
         cfg_ff.wait_fault_level  <= WAIT_FAULT_LEVEL_RST;
         cfg_ff.width_limit       <= WIDTH_LIMIT_RST;
         cfg_ff.width_fault_level <= WIDTH_FAULT_LEVEL_RST;
         cfg_ff.scale_recip       <= SCALE_RECIP_RST;
         cfg_ff.near_low          <= NEAR_LOW_RST;
         cfg_ff.near_high         <= NEAR_HIGH_RST;
      end else if (csr_write_en) begin
         unique case (csr_sel)
            CSR_TRIGGER_TICKS:     cfg_ff.trigger_ticks     <= csr_wdata[7:0];
            CSR_WAIT_LIMIT:        cfg_ff.wait_limit        <= csr_wdata;
            CSR_WAIT_FAULT_LEVEL:  cfg_ff.wait_fault_level  <= csr_wdata;
            CSR_WIDTH_LIMIT:       cfg_ff.width_limit       <= csr_wdata;
            CSR_WIDTH_FAULT_LEVEL: cfg_ff.width_fault_level <= csr_wdata;
            CSR_SCALE_RECIP:       cfg_ff.scale_recip       <= csr_wdata;
            CSR_NEAR_LOW:          cfg_ff.near_low          <= csr_wdata[RangeWidth-1:0];
            CSR_NEAR_HIGH:         cfg_ff.near_high         <= csr_wdata[RangeWidth-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_start_ff <= req_start_req;
         in_echo_ff  <= req_echo_level;
      end
   end

   // measurement sequencer
   uer_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .start_req  (in_start_ff),
      .echo_level (in_echo_ff),
      .cfg        (cfg_ff),
      .tick       (tick)
   );

   // distance scaling
   uer_scale u_scale (
      .tick          (tick),
      .cfg           (cfg_ff),
      .range_value   (range_value),
      .obstacle_near (obstacle_near)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_trigger_out   <= tick.trigger;
         rsp_busy_res      <= tick.busy;
         rsp_done_res      <= tick.done;
         rsp_status        <= tick.status;
         rsp_range_value   <= range_value;
         rsp_obstacle_near <= obstacle_near;
      end
   end

   assign rsp_valid = out_vld_ff;

   // a finished measurement always leaves the block idle
   a_done_not_busy : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> !rsp_busy_res)
      else $error("done reported while still busy");

   // fault results carry no distance
   a_fault_no_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |->
      (rsp_range_value == '0 && !rsp_obstacle_near))
      else $error("distance reported with a fault status");

   // status and flags are quiet on ticks that do not finish
   a_idle_fields_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_done_res) |->
      (rsp_status == STATUS_OK && rsp_range_value == '0 && !rsp_obstacle_near))
      else $error("result fields set on a tick that did not finish");

   // a stalled input register moves on once the result side frees up
   a_input_drains : assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !rsp_stall) |=> rsp_valid)
      else $error("queued request did not reach the result register");

endmodule

// File: tb/sv/tb_ultrasonic_echo_ranger.sv
// Self-checking testbench for ultrasonic_echo_ranger: a cycle-free tick predictor,
// directed measurement cases, then randomized ranging with handshake idling.
// Depends on uer_pkg and the ultrasonic_echo_ranger RTL.
module tb_ultrasonic_echo_ranger;
   timeunit 1ns;
   timeprecision 1ps;

   import uer_pkg::*;

   localparam int RandomTicks   = 150;
   localparam int CalmTicks     = 50;
   localparam int HoldCycles    = 60;
   localparam int WatchdogLimit = 5000;
   localparam int MaxPrinted    = 50;

   // expected content of one result transaction
   typedef struct packed {
      logic                  trigger;
      logic                  busy;
      logic                  done;
      status_type            status;
      logic [RangeWidth-1:0] range_value;
      logic                  near;
   } echo_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_start_req = 1'b0;
   logic                     req_echo_level = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_trigger_out;
   logic                     rsp_busy_res;
   logic                     rsp_done_res;
   logic [1:0]               rsp_status;
   logic [RangeWidth-1:0]    rsp_range_value;
   logic                     rsp_obstacle_near;
   logic                     csr_write_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   // predictor copy of the registers and measurement state
   cfg_type         cfg;
   phase_type       ph;
   logic [15:0]     cnt;

   echo_result_type expected_ticks[$];
   int              mismatch_count = 0;
   int              ticks_sent = 0;
   int              quiet_cycles = 0;
   int              idle_odds = 0;
   bit              hold_req = 1'b0;

   ultrasonic_echo_ranger i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_start_req     (req_start_req),
      .req_echo_level    (req_echo_level),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_trigger_out   (rsp_trigger_out),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_done_res      (rsp_done_res),
      .rsp_status        (rsp_status),
      .rsp_range_value   (rsp_range_value),
      .rsp_obstacle_near (rsp_obstacle_near),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      cfg.trigger_ticks     = TRIGGER_TICKS_RST;
      cfg.wait_limit        = WAIT_LIMIT_RST;
      cfg.wait_fault_level  = WAIT_FAULT_LEVEL_RST;
      cfg.width_limit       = WIDTH_LIMIT_RST;
      cfg.width_fault_level = WIDTH_FAULT_LEVEL_RST;
      cfg.scale_recip       = SCALE_RECIP_RST;
      cfg.near_low          = NEAR_LOW_RST;
      cfg.near_high         = NEAR_HIGH_RST;
      ph  = PH_IDLE;
      cnt = '0;
   end

   // end of a measurement: scale the width and check the near window
   function automatic echo_result_type finish_measurement(input status_type st,
                                                          input logic [15:0] w);
      echo_result_type r;
      logic [31:0]     product;
      logic [15:0]     distance;
      r = '0;
      r.done = 1'b1;
      r.status = st;
      if (st == STATUS_OK) begin
         product = w * cfg.scale_recip;
         distance = product[31:16];
         if (distance > 16'(RANGE_MAX))
            distance = 16'(RANGE_MAX);
         r.range_value = distance[RangeWidth-1:0];
         r.near = (distance[RangeWidth-1:0] >= cfg.near_low) &&
                  (distance[RangeWidth-1:0] <= cfg.near_high);
      end
      ph  = PH_IDLE;
      cnt = '0;
      return r;
   endfunction

   // advance the ranger by one tick and return the result it gives
   function automatic echo_result_type step_ranger(input logic start, input logic echo);
      echo_result_type r;
      r = '0;
      case (ph)
         PH_IDLE: begin
            if (start) begin
               r.trigger = 1'b1;
               cnt = 16'd1;
               ph  = PH_TRIG;
               if (cnt >= 16'(cfg.trigger_ticks)) begin
                  ph  = PH_WAIT;
                  cnt = '0;
               end
            end
         end
         PH_TRIG: begin
            r.trigger = 1'b1;
            cnt = cnt + 16'd1;
            if (cnt >= 16'(cfg.trigger_ticks)) begin
               ph  = PH_WAIT;
               cnt = '0;
            end
         end
         PH_WAIT: begin
            if (echo) begin
               if (cnt > cfg.wait_fault_level) begin
                  r = finish_measurement(STATUS_NO_ECHO, '0);
               end else begin
                  ph  = PH_WIDTH;
                  cnt = '0;
               end
            end else begin
               cnt = cnt + 16'd1;
               if (cnt >= cfg.wait_limit)
                  r = finish_measurement(STATUS_NO_ECHO, '0);
            end
         end
         default: begin
            if (echo) begin
               cnt = cnt + 16'd1;
               if (cnt >= cfg.width_limit)
                  r = finish_measurement((cnt > cfg.width_fault_level) ?
                                         STATUS_OVERRUN : STATUS_OK, cnt);
            end else begin
               r = finish_measurement((cnt > cfg.width_fault_level) ?
                                      STATUS_OVERRUN : STATUS_OK, cnt);
            end
         end
      endcase
      r.busy = (ph != PH_IDLE);
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      if (mismatch_count < MaxPrinted)
         $display("MISMATCH %s: got %0d, expected %0d (at %0t)", field, got, want, $realtime);
      mismatch_count++;
   endtask

   // one tick transaction on the request channel, with an optional gap after it
   task automatic send_tick(input logic start, input logic echo);
      req_valid      <= 1'b1;
      req_start_req  <= start;
      req_echo_level <= echo;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_ticks.push_back(step_ranger(start, echo));
      ticks_sent++;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_TRIGGER_TICKS:     cfg.trigger_ticks     = value[7:0];
         CSR_WAIT_LIMIT:        cfg.wait_limit        = value;
         CSR_WAIT_FAULT_LEVEL:  cfg.wait_fault_level  = value;
         CSR_WIDTH_LIMIT:       cfg.width_limit       = value;
         CSR_WIDTH_FAULT_LEVEL: cfg.width_fault_level = value;
         CSR_SCALE_RECIP:       cfg.scale_recip       = value;
         CSR_NEAR_LOW:          cfg.near_low          = value[RangeWidth-1:0];
         default:               cfg.near_high         = value[RangeWidth-1:0];
      endcase
   endtask

   task automatic load_config(input logic [15:0] trig, input logic [15:0] wl,
                              input logic [15:0] wfl, input logic [15:0] xl,
                              input logic [15:0] xfl, input logic [15:0] sc,
                              input logic [15:0] nl, input logic [15:0] nh);
      drain_results();
      write_reg(CSR_TRIGGER_TICKS, trig);
      write_reg(CSR_WAIT_LIMIT, wl);
      write_reg(CSR_WAIT_FAULT_LEVEL, wfl);
      write_reg(CSR_WIDTH_LIMIT, xl);
      write_reg(CSR_WIDTH_FAULT_LEVEL, xfl);
      write_reg(CSR_SCALE_RECIP, sc);
      write_reg(CSR_NEAR_LOW, nl);
      write_reg(CSR_NEAR_HIGH, nh);
   endtask

   // a well-formed measurement: start, trigger, echo rise after a delay, echo width
   task automatic run_measurement(input int rise_delay, input int echo_ticks);
      int n;
      send_tick(1'b1, 1'($urandom));
      // start and echo are both ignored while the trigger is driven
      while (ph == PH_TRIG) send_tick(1'($urandom), 1'($urandom));
      n = 0;
      while (ph == PH_WAIT && n < rise_delay) begin
         send_tick(1'($urandom), 1'b0);
         n++;
      end
      if (ph == PH_WAIT) send_tick(1'($urandom), 1'b1);
      n = 0;
      while (ph == PH_WIDTH && n < echo_ticks) begin
         send_tick(1'($urandom), 1'b1);
         n++;
      end
      if (ph == PH_WIDTH) send_tick(1'($urandom), 1'b0);
   endtask

   // reset values of every register
   task automatic test_default_config();
      run_measurement(0, 2);
   endtask

   // zero trigger length, zero wait limit, timeout and late echo rise
   task automatic test_echo_timing();
      load_config(16'd0, 16'd0, 16'hFFFF, 16'd8, 16'd8, 16'hFFFF, 16'd0, 16'd1023);
      run_measurement(3, 2);
      drain_results();
      write_reg(CSR_WAIT_LIMIT, 16'd3);
      run_measurement(5, 1);
      drain_results();
      write_reg(CSR_WAIT_LIMIT, 16'd20);
      write_reg(CSR_WAIT_FAULT_LEVEL, 16'd2);
      run_measurement(4, 1);
      drain_results();
      write_reg(CSR_WAIT_FAULT_LEVEL, 16'd0);
      run_measurement(0, 1);
   endtask

   // zero width limit, width limit reached, overrun and the near window
   task automatic test_echo_width();
      load_config(16'd1, 16'd10, 16'd10, 16'd0, 16'd3, 16'd32768, 16'd1, 16'd2);
      run_measurement(0, 5);
      drain_results();
      write_reg(CSR_WIDTH_LIMIT, 16'd6);
      run_measurement(1, 10);
      run_measurement(0, 3);
      drain_results();
      // inverted window flags nothing
      write_reg(CSR_NEAR_LOW, 16'd2);
      write_reg(CSR_NEAR_HIGH, 16'd1);
      run_measurement(0, 2);
   endtask

   // register writes while a measurement is in progress
   task automatic test_midmeasure_write();
      int k;
      load_config(16'd2, 16'd30, 16'd30, 16'd30, 16'd30, 16'd8192, 16'd0, 16'd0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      for (k = 0; k < 5; k++) send_tick(1'b0, 1'b0);
      drain_results();
      write_reg(CSR_WAIT_LIMIT, 16'd3);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      for (k = 0; k < 4; k++) send_tick(1'b0, 1'b1);
      drain_results();
      write_reg(CSR_SCALE_RECIP, 16'hFFFF);
      send_tick(1'b0, 1'b0);
   endtask

   // receiver holds off while requests keep coming
   task automatic test_backpressure();
      load_config(16'd3, 16'd20, 16'd20, 16'd30, 16'd25, 16'd20000, 16'd1, 16'd5);
      idle_odds = 0;
      hold_req = 1'b1;
      run_measurement(2, 12);
      run_measurement(4, 20);
      drain_results();
   endtask

   // register extremes, including a saturated distance
   task automatic test_register_extremes();
      load_config(16'hFF03, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFC00);
      run_measurement(0, 3);
      run_measurement(1, 3);
      drain_results();
      write_reg(CSR_TRIGGER_TICKS, 16'd1);
      write_reg(CSR_WIDTH_FAULT_LEVEL, 16'hFFFF);
      write_reg(CSR_SCALE_RECIP, 16'hFFFF);
      write_reg(CSR_NEAR_LOW, 16'd0);
      write_reg(CSR_NEAR_HIGH, 16'd1023);
      run_measurement(0, 1030);
      drain_results();
      write_reg(CSR_SCALE_RECIP, 16'd0);
      write_reg(CSR_NEAR_HIGH, 16'd0);
      run_measurement(0, 5);
   endtask

   task automatic randomize_config();
      load_config({8'($urandom), 8'($urandom_range(0, 6))},
                  ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 30)),
                  ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(0, 32)),
                  ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 40)),
                  ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(0, 45)),
                  16'($urandom),
                  {6'($urandom), 10'($urandom_range(0, 20))},
                  {6'($urandom), 10'($urandom_range(0, 40))});
   endtask

   // random settings, mostly well-formed measurements with some noise ticks
   task automatic test_random_ranging();
      int first_tick;
      first_tick = ticks_sent;
      while (ticks_sent - first_tick < RandomTicks) begin
         randomize_config();
         case ($urandom_range(0, 3))
            0:       idle_odds = 0;
            1:       idle_odds = 3;
            2:       idle_odds = 8;
            default: idle_odds = 20;
         endcase
         repeat ($urandom_range(3, 8)) begin
            // no idling on either side near the end of the run
            if (RandomTicks - (ticks_sent - first_tick) < CalmTicks) idle_odds = 0;
            if ($urandom_range(0, 5) == 0) begin
               repeat ($urandom_range(1, 12))
                  send_tick($urandom_range(0, 3) == 0, 1'($urandom));
            end else begin
               run_measurement($urandom_range(0, 35), $urandom_range(0, 45));
            end
         end
      end
   endtask

   // receiver side stall: random bursts, or one long hold on request
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin : check_results
      echo_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_ticks.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
         end else begin
            want = expected_ticks.pop_front();
            if (rsp_trigger_out !== want.trigger)
               report_mismatch("trigger_out", rsp_trigger_out, want.trigger);
            if (rsp_busy_res !== want.busy)
               report_mismatch("busy_res", rsp_busy_res, want.busy);
            if (rsp_done_res !== want.done)
               report_mismatch("done_res", rsp_done_res, want.done);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_range_value !== want.range_value)
               report_mismatch("range_value", rsp_range_value, want.range_value);
            if (rsp_obstacle_near !== want.near)
               report_mismatch("obstacle_near", rsp_obstacle_near, want.near);
         end
      end
   end

   // end the run when no transaction moves for too long
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : run_tests
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      idle_odds = 4;
      test_default_config();
      test_echo_timing();
      test_echo_width();
      test_midmeasure_write();
      test_backpressure();
      idle_odds = 6;
      test_register_extremes();
      test_random_ranging();
      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_ticks.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
